/* hdl/cwm_pkg.sv */
// ----------------------------------------------------------------------------
// cwm_pkg
// types, constants and the sine table function of the word mixer
// ----------------------------------------------------------------------------
package cwm_pkg;

	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int SINE_IDX_W = $clog2(SINE_TABLE_DEPTH);
	localparam int DIGIT_W = 4;
	localparam int DIGITS = 32 / DIGIT_W;
	localparam int CNT_W = $clog2(DIGITS);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W = 10;

	localparam logic [CFG_IDX_W-1:0] REG_SEED_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEED_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEED_Z = 2'd2;

	localparam logic [31:0] K_LOGI = 32'd4284229140;
	localparam logic [31:0] K_03 = 32'd1288490189;
	localparam logic [31:0] K_GOLD = 32'd2654435761;
	localparam logic [63:0] K_PI = 64'd3373259369;

	// thousandths to Q0.32: s * 2^29 / 125 = s * 4294967 + s * 37 / 125
	localparam logic [31:0] SEED_WHOLE = 32'd4294967;
	localparam logic [23:0] SEED_RECIP = 24'd8589935;

	// multiplier operation codes
	localparam logic [2:0] OP_LOGI_P = 3'd0;
	localparam logic [2:0] OP_LOGI_K = 3'd1;
	localparam logic [2:0] OP_CPL_Y = 3'd2;
	localparam logic [2:0] OP_CPL_Z = 3'd3;
	localparam logic [2:0] OP_CPL_X = 3'd4;
	localparam logic [2:0] OP_GOLD = 3'd5;

	typedef struct packed {
		logic [31:0] data_word;
		logic        last_of_buffer;
	} in_item_t;

	typedef struct packed {
		logic [31:0] mixed_word;
		logic [31:0] chaos_value;
	} out_item_t;

	typedef struct packed {
		logic        start;
		logic [31:0] a;
		logic [31:0] b;
	} mul_req_t;

	// sine entry, elaborated into a constant table
	function automatic logic [31:0] sin_entry(input int i);
		logic [63:0] j, a, a2, term, pos, neg, d;
		j = (i <= SINE_TABLE_DEPTH / 2) ? 64'(i) : 64'(SINE_TABLE_DEPTH - i);
		a = (K_PI * j) / 64'(SINE_TABLE_DEPTH);
		a2 = (a * a) >> 30;
		term = a;
		pos = a;
		neg = 64'd0;
		for (int k = 1; k <= 5; k++) begin
			term = ((term * a2) >> 30) / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1)
				neg = neg + term;
			else
				pos = pos + term;
		end
		d = (pos > neg) ? ((pos - neg) << 2) : 64'd0;
		return (d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
	endfunction

	typedef logic [31:0] sine_rom_t [SINE_TABLE_DEPTH];

	function automatic sine_rom_t build_sine();
		sine_rom_t t;
		for (int i = 0; i < SINE_TABLE_DEPTH; i++)
			t[i] = sin_entry(i);
		return t;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine();

	// seed: thousandths to Q0.32, out of range folded, zero to default
	function automatic logic [31:0] seed_q32(input logic [CFG_W-1:0] r,
			input logic [CFG_W-1:0] dflt);
		logic [CFG_W-1:0] s;
		logic [15:0] t;
		logic [39:0] f;
		s = (r >= CFG_W'(1000)) ? CFG_W'(r - CFG_W'(1000)) : r;
		if (s == '0)
			s = dflt;
		t = 16'(s) * 16'd37;
		f = 40'(t) * 40'(SEED_RECIP);
		return 32'(s) * SEED_WHOLE + 32'(f[39:30]);
	endfunction

endpackage

/* hdl/chaotic_word_mixer.sv */
// ----------------------------------------------------------------------------
// chaotic_word_mixer
// scrambles 32-bit words with three coupled chaotic maps, one serial multiplier
// ----------------------------------------------------------------------------
// channel | direction | handshake        | payload
// in      | into      | in_valid/in_stall | data_word, last_of_buffer
// out     | out of    | out_valid/out_stall | mixed_word, chaos_value
// cfg     | into      | cfg_we            | cfg_idx, cfg_data
// an item runs six products through the 4-bit serial multiplier besides the
// acceptance, the map update, the mask and the output; the multiplier sets
// the rate
// reset clears control and loads the default seeds; the maps reseed on the
// first item and after an item marked last
// a result waits in the output register; the next item is taken while it waits
// ----------------------------------------------------------------------------
module chaotic_word_mixer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  cwm_pkg::in_item_t          in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output cwm_pkg::out_item_t         out_data,
	input  logic                       cfg_we,
	input  logic [cwm_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [cwm_pkg::CFG_W-1:0]  cfg_data
);
	import cwm_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MAPS = 4'd1;
	localparam logic [3:0] ST_LOGI_P = 4'd2;
	localparam logic [3:0] ST_LOGI_K = 4'd3;
	localparam logic [3:0] ST_CPL_Y = 4'd4;
	localparam logic [3:0] ST_CPL_Z = 4'd5;
	localparam logic [3:0] ST_CPL_X = 4'd6;
	localparam logic [3:0] ST_MASK = 4'd7;
	localparam logic [3:0] ST_GOLD = 4'd8;
	localparam logic [3:0] ST_DONE = 4'd9;

	logic [3:0] state_q;
	logic [CFG_W-1:0] seed_x_q, seed_y_q, seed_z_q;
	logic [31:0] cx_q, cy_q, cz_q;
	logic [31:0] x_q, y_q, z_q, c_q, w_q, tmp_q;
	logic [31:0] sine_q;
	logic reseed_q, last_q, issued_q;
	mul_req_t req;
	logic mdone;
	logic [63:0] prod;
	logic [31:0] sx, sy, sz, xs, ys, zs, tent, rot;
	logic [32:0] tw;
	logic [SINE_IDX_W-1:0] sidx;
	out_item_t out_q;
	logic out_v_q;

	cwm_mul u_mul (.clk(clk), .arst_n(arst_n), .req(req), .done(mdone), .prod(prod));

	assign sx = seed_q32(seed_x_q, CFG_W'(123));
	assign sy = seed_q32(seed_y_q, CFG_W'(456));
	assign sz = seed_q32(seed_z_q, CFG_W'(789));
	assign xs = reseed_q ? sx : cx_q;
	assign ys = reseed_q ? sy : cy_q;
	assign zs = reseed_q ? sz : cz_q;

	assign tw = ys[31] ? (33'h1_0000_0000 - 33'(ys)) << 1 : 33'(ys) << 1;
	assign tent = tw[32] ? 32'hFFFF_FFFF : tw[31:0];
	assign sidx = zs[31 -: SINE_IDX_W];

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		req = '0;
		if (!issued_q) begin
			case (state_q)
				ST_LOGI_P: begin
					req.start = 1'b1;
					req.a = x_q;
					req.b = 32'(33'h1_0000_0000 - 33'(x_q));
				end
				ST_LOGI_K: begin
					req.start = 1'b1;
					req.a = tmp_q;
					req.b = K_LOGI;
				end
				ST_CPL_Y: begin
					req.start = 1'b1;
					req.a = y_q;
					req.b = K_03;
				end
				ST_CPL_Z: begin
					req.start = 1'b1;
					req.a = z_q;
					req.b = K_03;
				end
				ST_CPL_X: begin
					req.start = 1'b1;
					req.a = x_q;
					req.b = K_03;
				end
				ST_GOLD: begin
					req.start = 1'b1;
					req.a = rot;
					req.b = K_GOLD;
				end
				default: req = '0;
			endcase
		end
	end

	// x = 0 gives 1 - x = 2^32; its low word is 0 and the product is 0 anyway
	always_comb begin
		logic [63:0] rr;
		rr = {w_q, w_q} << c_q[3:0];
		rot = rr[63:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_x_q <= CFG_W'(123);
			seed_y_q <= CFG_W'(456);
			seed_z_q <= CFG_W'(789);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SEED_X: seed_x_q <= cfg_data;
				REG_SEED_Y: seed_y_q <= cfg_data;
				REG_SEED_Z: seed_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			reseed_q <= 1'b1;
			issued_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (out_v_q && !out_stall && state_q != ST_DONE)
				out_v_q <= 1'b0;
			if (req.start)
				issued_q <= 1'b1;
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_MAPS;
				ST_MAPS: begin
					state_q <= ST_LOGI_P;
					reseed_q <= 1'b0;
				end
				ST_LOGI_P, ST_LOGI_K, ST_CPL_Y, ST_CPL_Z, ST_CPL_X: if (mdone) begin
					issued_q <= 1'b0;
					state_q <= state_q + 4'd1;
				end
				ST_MASK: state_q <= ST_GOLD;
				ST_GOLD: if (mdone) begin
					issued_q <= 1'b0;
					state_q <= ST_DONE;
				end
				ST_DONE: if (!out_v_q || !out_stall) begin
					out_v_q <= 1'b1;
					state_q <= ST_IDLE;
					if (last_q)
						reseed_q <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		sine_q <= SINE_ROM[sidx];
		case (state_q)
			ST_IDLE: if (in_valid) begin
				w_q <= in_data.data_word;
				last_q <= in_data.last_of_buffer;
			end
			ST_MAPS: begin
				x_q <= xs;
				y_q <= tent;
				z_q <= sine_q;
			end
			ST_LOGI_P: begin
				if (mdone) tmp_q <= prod[63:32];
			end
			ST_LOGI_K: if (mdone) begin
				x_q <= (prod[63:62] != 2'b00) ? 32'hFFFF_FFFF : prod[61:30];
			end
			ST_CPL_Y: if (mdone) cx_q <= x_q + prod[63:32];
			ST_CPL_Z: if (mdone) cy_q <= y_q + prod[63:32];
			ST_CPL_X: if (mdone) cz_q <= z_q + prod[63:32];
			ST_MASK: begin
				c_q <= cx_q + cy_q + cz_q;
				w_q <= w_q ^ (cx_q + cy_q + cz_q);
			end
			ST_DONE: if (!out_v_q || !out_stall) begin
				out_q.mixed_word <= prod[31:0];
				out_q.chaos_value <= c_q;
			end
			default: ;
		endcase
	end

	assign out_valid = out_v_q;
	assign out_data = out_q;

`ifndef SYNTHESIS
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall) else $error("item taken while busy");
	a_reseed_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MAPS |=> !reseed_q) else $error("reseed not cleared");
	a_single_req: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> !req.start) else $error("double multiply start");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
`endif

endmodule

/* hdl/cwm_mul.sv */
// ----------------------------------------------------------------------------
// cwm_mul
// digit-serial 32 x 32 multiplier, 4 bits of b per cycle, 64-bit product
// ----------------------------------------------------------------------------
module cwm_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  cwm_pkg::mul_req_t req,
	output logic              done,
	output logic [63:0]       prod
);
	import cwm_pkg::*;

	logic [31:0] a_q;
	logic [31:0] b_q;
	logic [63:0] acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic [35:0] pp;

	// shift-and-add, most significant digit first
	assign pp = 36'(a_q) * 36'(b_q[31:28]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIGITS - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q << DIGIT_W) + 64'(pp);
			b_q <= b_q << DIGIT_W;
		end
	end

	assign prod = acc_q;

`ifndef SYNTHESIS
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("mul done held");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy_q)) else $error("mul done without work");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !req.start |=> busy_q || done) else $error("mul lost work");
`endif

endmodule
